### hw/rtl/rmmn_pkg.sv
// ----------------------------------------------------------------------------
// rmmn_pkg
// Shared types and constants of the running min/max normalizer: data widths,
// reset values, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rmmn_pkg;

  localparam int unsigned DataW              = 16;
  localparam int unsigned VectorDepthDefault = 32;
  localparam int unsigned DivSteps           = DataW;
  localparam int unsigned StepW              = $clog2(DivSteps);
  localparam logic [DataW-1:0] ScaleTopReset = 16'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIDEN,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } rmmn_state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic store;     // take one sample into buffer and vector extremes
    logic widen;     // fold vector extremes into running extremes
    logic rd_issue;  // read buffer entry at the result index
    logic mul_load;  // form offset * scale and load the divider
    logic div_step;  // one restoring division step
    logic next_idx;  // advance to next buffered sample
    logic finish;    // end of vector: clear per-vector state
  } rmmn_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic div_last;   // current division step is the final one
    logic last_item;  // result index points at the last buffered sample
  } rmmn_sts_t;

endpackage

### hw/rtl/running_minmax_normalizer_unit.sv
// ----------------------------------------------------------------------------
// running_minmax_normalizer_unit
// Buffers a vector of signed Q8.8 samples and, at its last sample, emits each
// one scaled into 0..scale_top across the running min/max span.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata carries one sample, s_axis_tlast marks the
//   final sample of a vector. Samples that are not last keep the input ready.
//   Up to VECTOR_DEPTH samples are stored; later ones only widen the vector
//   extremes and set the overflow flag carried on every result in m_axis_tuser.
//   After the last sample the input stalls while one result per stored sample
//   leaves on the output stream, in arrival order, tlast on the final one.
//   Each result passes through a buffer read, one multiply and a 16-step
//   restoring divider that yields one quotient bit a cycle, then waits for
//   the output. A stalled receiver holds the result and the whole unit until
//   taken. Reset clears running and vector extremes to zero and sets
//   scale_top to 1024; the buffer needs no clearing. Write scale_top with
//   cfg_we_i only while the unit is idle.
// ----------------------------------------------------------------------------
module running_minmax_normalizer_unit #(
  parameter int unsigned VECTOR_DEPTH = rmmn_pkg::VectorDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rmmn_pkg::DataW-1:0] cfg_wdata_i,    // scale_top
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rmmn_pkg::DataW-1:0] s_axis_tdata,   // [15:0] sample
  input  logic                       s_axis_tlast,   // end_of_vector
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rmmn_pkg::DataW-1:0] m_axis_tdata,   // [15:0] scaled_value
  output logic                       m_axis_tlast,   // last_of_vector
  output logic [0:0]                 m_axis_tuser    // [0] overflow
);
  import rmmn_pkg::*;

  rmmn_cmd_t cmd;
  rmmn_sts_t sts;

  rmmn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid)
  );

  rmmn_datapath #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (s_axis_tdata),
    .scaled_value_o   (m_axis_tdata),
    .last_of_vector_o (m_axis_tlast),
    .overflow_o       (m_axis_tuser[0])
  );

  // Results and new samples never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // A last sample stops intake for the output phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("intake continued after last sample");

  // A sample that is not last keeps the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> s_axis_tready)
    else $error("intake stalled after non-last sample");

  // The final result of a vector returns the unit to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("unit not idle after final result");

endmodule

### hw/rtl/rmmn_ram.sv
// ----------------------------------------------------------------------------
// rmmn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmmn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rmmn_ctrl.sv
// ----------------------------------------------------------------------------
// rmmn_ctrl
// Controller: collects samples, then walks the buffer through read,
// multiply, serial divide and output for each stored sample.
// ----------------------------------------------------------------------------
module rmmn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tready,
  input  rmmn_pkg::rmmn_sts_t sts_i,
  output rmmn_pkg::rmmn_cmd_t cmd_o,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid
);
  import rmmn_pkg::*;

  rmmn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tlast) begin
          state_d = ST_WIDEN;
        end
      end
      ST_WIDEN: state_d = ST_READ;
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = sts_i.last_item ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.store   = s_axis_tvalid;
      end
      ST_WIDEN: cmd_o.widen    = 1'b1;
      ST_READ:  cmd_o.rd_issue = 1'b1;
      ST_MUL:   cmd_o.mul_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cmd_o.finish   = sts_i.last_item;
          cmd_o.next_idx = !sts_i.last_item;
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/rmmn_datapath.sv
// ----------------------------------------------------------------------------
// rmmn_datapath
// Sample buffer, vector and running extremes, scale register, one 16x16
// multiplier and a restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmmn_datapath #(
  parameter int unsigned VECTOR_DEPTH = rmmn_pkg::VectorDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmmn_pkg::rmmn_cmd_t         cmd_i,
  output rmmn_pkg::rmmn_sts_t         sts_o,
  input  logic                        cfg_we_i,
  input  logic [rmmn_pkg::DataW-1:0]  cfg_wdata_i,
  input  logic [rmmn_pkg::DataW-1:0]  sample_i,
  output logic [rmmn_pkg::DataW-1:0]  scaled_value_o,
  output logic                        last_of_vector_o,
  output logic                        overflow_o
);
  import rmmn_pkg::*;

  localparam int unsigned CW = $clog2(VECTOR_DEPTH + 1);
  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           rd_idx_q, rd_idx_d;
  logic signed [DataW-1:0] vmin_q, vmin_d, vmax_q, vmax_d;
  logic signed [DataW-1:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic                    dropped_q, dropped_d;
  logic [DataW-1:0]        scale_top_q;

  logic [DataW-1:0]        span_q;
  logic                    span_zero_q;
  logic [DataW-1:0]        rem_q, rem_d;
  logic [DataW-1:0]        quo_q, quo_d;
  logic [StepW-1:0]        step_q, step_d;

  logic signed [DataW-1:0] sample_s;
  logic                    buf_we;
  logic [DataW-1:0]        rdata;
  logic [DataW:0]          off_wide;
  logic [DataW:0]          span_wide;
  logic [2*DataW-1:0]      prod;
  logic [DataW:0]          trial;
  logic [DataW:0]          trial_sub;
  logic                    trial_ge;
  logic [CW:0]             idx_inc;

  assign sample_s = $signed(sample_i);
  assign buf_we   = cmd_i.store && (count_q < CW'(VECTOR_DEPTH));

  rmmn_ram #(
    .WIDTH (DataW),
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sample_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Offsets and span never exceed 16 bits since rmin <= x <= rmax
  assign off_wide  = {rdata[DataW-1], rdata} - {rmin_q[DataW-1], rmin_q};
  assign span_wide = {rmax_q[DataW-1], rmax_q} - {rmin_q[DataW-1], rmin_q};
  assign prod      = (2*DataW)'(off_wide[DataW-1:0]) * (2*DataW)'(scale_top_q);

  // Restoring step: the quotient bits shift into quo_q as dividend bits leave
  assign trial     = {rem_q, quo_q[DataW-1]};
  assign trial_ge  = trial >= {1'b0, span_q};
  assign trial_sub = trial - {1'b0, span_q};

  assign idx_inc = {1'b0, rd_idx_q} + 1'b1;

  always_comb begin
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    vmin_d    = vmin_q;
    vmax_d    = vmax_q;
    rmin_d    = rmin_q;
    rmax_d    = rmax_q;
    dropped_d = dropped_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;

    if (cmd_i.store) begin
      if (count_q == '0) begin
        vmin_d = sample_s;
        vmax_d = sample_s;
      end else begin
        if (sample_s < vmin_q) vmin_d = sample_s;
        if (sample_s > vmax_q) vmax_d = sample_s;
      end
      if (buf_we) begin
        count_d = count_q + 1'b1;
      end else begin
        dropped_d = 1'b1;
      end
    end

    if (cmd_i.widen) begin
      if (vmin_q < rmin_q) rmin_d = vmin_q;
      if (vmax_q > rmax_q) rmax_d = vmax_q;
    end

    if (cmd_i.mul_load) begin
      // High half is below the span, so the quotient fits in 16 bits
      rem_d  = prod[2*DataW-1:DataW];
      quo_d  = prod[DataW-1:0];
      step_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d  = trial_ge ? trial_sub[DataW-1:0] : trial[DataW-1:0];
      quo_d  = {quo_q[DataW-2:0], trial_ge};
      step_d = step_q + 1'b1;
    end

    if (cmd_i.next_idx) begin
      rd_idx_d = idx_inc[CW-1:0];
    end

    if (cmd_i.finish) begin
      rd_idx_d  = '0;
      count_d   = '0;
      vmin_d    = '0;
      vmax_d    = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      vmin_q      <= '0;
      vmax_q      <= '0;
      rmin_q      <= '0;
      rmax_q      <= '0;
      dropped_q   <= 1'b0;
      scale_top_q <= ScaleTopReset;
    end else begin
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      vmin_q    <= vmin_d;
      vmax_q    <= vmax_d;
      rmin_q    <= rmin_d;
      rmax_q    <= rmax_d;
      dropped_q <= dropped_d;
      if (cfg_we_i) begin
        scale_top_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.mul_load) begin
      span_q      <= span_wide[DataW-1:0];
      span_zero_q <= (span_wide[DataW-1:0] == '0);
    end
  end

  assign sts_o.div_last  = (step_q == StepW'(DivSteps - 1));
  assign sts_o.last_item = (idx_inc == {1'b0, count_q});

  assign scaled_value_o   = span_zero_q ? '0 : quo_q;
  assign last_of_vector_o = sts_o.last_item;
  assign overflow_o       = dropped_q;

endmodule

### tb/sv/rmmn_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmmn_scoreboard
// Watches the configuration port and both streams of the normalizer. Keeps
// its own sample buffer, vector and running extremes, and predicts every
// result when a vector ends. Compares each output transaction field by
// field against the oldest prediction and counts failures for the top.
// ----------------------------------------------------------------------------
module rmmn_scoreboard #(
  parameter int unsigned Depth = rmmn_pkg::VectorDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rmmn_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [rmmn_pkg::DataW-1:0] s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [rmmn_pkg::DataW-1:0] m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic [0:0]                 m_axis_tuser,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  import rmmn_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] scaled;
    logic             last;
    logic             overflow;
  } norm_result_t;

  norm_result_t     scaled_q[$];
  int               sample_store[Depth];
  int unsigned      held;
  int               run_min;
  int               run_max;
  int               vec_min;
  int               vec_max;
  logic             dropped;
  logic [DataW-1:0] scale_top;
  int               fails   = 0;
  int               checked = 0;
  int               pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic logic [DataW-1:0] normalize(int x);
    longint span;
    longint offset;
    longint quot;
    span   = longint'(run_max) - longint'(run_min);
    offset = longint'(x) - longint'(run_min);
    if (span == 0) begin
      return '0;
    end
    quot = (offset * longint'(scale_top)) / span;
    return quot[DataW-1:0];
  endfunction

  task automatic take_sample(int x, logic last);
    norm_result_t r;
    if (held == 0) begin
      vec_min = x;
      vec_max = x;
    end else begin
      if (x < vec_min) vec_min = x;
      if (x > vec_max) vec_max = x;
    end
    // Dropped samples still widen the vector extremes
    if (held < Depth) begin
      sample_store[held] = x;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      if (vec_min < run_min) run_min = vec_min;
      if (vec_max > run_max) run_max = vec_max;
      for (int unsigned i = 0; i < held; i++) begin
        r.scaled   = normalize(sample_store[i]);
        r.last     = (i + 1 == held);
        r.overflow = dropped;
        scaled_q   = {scaled_q, r};
      end
      held    = 0;
      vec_min = 0;
      vec_max = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic compare_result();
    norm_result_t want;
    if (scaled_q.size() == 0) begin
      $display("%0t: result with nothing expected: value %0d last %0b overflow %0b",
               $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      fails++;
      return;
    end
    want = scaled_q.pop_front();
    checked++;
    if (want.scaled !== m_axis_tdata || want.last !== m_axis_tlast ||
        want.overflow !== m_axis_tuser[0]) begin
      $display("%0t: mismatch: expected %0d last %0b ovf %0b, actual %0d last %0b ovf %0b",
               $time, want.scaled, want.last, want.overflow,
               m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held      = 0;
      run_min   = 0;
      run_max   = 0;
      vec_min   = 0;
      vec_max   = 0;
      dropped   = 1'b0;
      scale_top = ScaleTopReset;
      scaled_q.delete();
      pending   = 0;
    end else begin
      if (cfg_we_i) begin
        scale_top = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        compare_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_sample(int'($signed(s_axis_tdata)), s_axis_tlast);
      end
      pending = scaled_q.size();
    end
  end

endmodule

### tb/sv/tb_running_minmax_normalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_minmax_normalizer_unit
// Drives sample vectors into the normalizer under several scale_top settings
// (reset value, 1, 65535, 0 and a random one) with random gaps on the input
// and random backpressure on the output. The scoreboard predicts and checks
// every result; this top only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_running_minmax_normalizer_unit;
  import rmmn_pkg::*;

  localparam int unsigned Depth = VectorDepthDefault;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [DataW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic [0:0]       m_axis_tuser;

  int fail_count;
  int pending;
  int checked;

  int samples_sent  = 0;
  int vectors_sent  = 0;
  int overflow_vecs = 0;
  int ready_hold    = 0;
  int ready_roll;

  running_minmax_normalizer_unit #(
    .VECTOR_DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  rmmn_scoreboard #(
    .Depth(Depth)
  ) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Output backpressure: mostly short holds, a few long stalls and long free runs
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 65) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(0, 11);
      end else if (ready_roll < 75) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(40, 80);
      end else if (ready_roll < 95) begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(15, 50);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 12);
    if (r < 93) return $urandom_range(13, 31);
    return $urandom_range(32, 36);
  endfunction

  function automatic logic [DataW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return DataW'($urandom_range(0, 65535));
    if (r < 80) return DataW'($urandom_range(0, 1024) - 512);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Hold valid across back-to-back transactions; lower it only for a gap
  task automatic send_sample(logic [DataW-1:0] value, logic last, bit burst);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
    if (last) vectors_sent++;
  endtask

  task automatic send_random_vector(int len);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    if (len > Depth) overflow_vecs++;
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(), i == len - 1, burst);
    end
  endtask

  // Drain all results, then let the unit settle back to idle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [DataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int               phase_items;
    int               len;
    logic [DataW-1:0] scale;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero span, then widen the running range step by step
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h0100, 1'b0, 1'b0);
    send_sample(16'h0080, 1'b1, 1'b0);
    send_sample(16'hFF00, 1'b1, 1'b1);
    send_sample(16'h1234, 1'b0, 1'b1);
    send_sample(16'h1234, 1'b0, 1'b1);
    send_sample(16'h1234, 1'b1, 1'b1);
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b0, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    wait_drained();

    // Random phases, each under its own scale_top
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       scale = 16'd1;
        1:       scale = 16'hFFFF;
        2:       scale = 16'd0;
        default: scale = DataW'($urandom_range(2, 65534));
      endcase
      write_scale(scale);
      phase_items = 0;
      while (phase_items < 20) begin
        // First vector of the early phases hits the buffer boundary
        if (phase_items == 0 && p == 0) len = Depth;
        else if (phase_items == 0 && p == 1) len = Depth + 2;
        else len = pick_length();
        send_random_vector(len);
        phase_items += len;
      end
      wait_drained();
    end

    $display("covered %0d samples in %0d vectors, %0d of them past buffer depth",
             samples_sent, vectors_sent, overflow_vecs);
    $display("scale_top at reset value, 1, 65535, 0 and random; %0d results compared",
             checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
